// ----- sv/bt2_pkg.sv -----
package bt2_pkg;

    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic [CNT_W-1:0] CNT_STRONG_TAKEN     = 2'd3;
    localparam logic [CNT_W-1:0] CNT_STRONG_NOT_TAKEN = 2'd0;

    typedef enum logic
    {
        KIND_ALLOC   = 1'b0,
        KIND_RESOLVE = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [ADDR_W-1:0]  branch_addr;
        logic               already_hit;
        logic               start_taken;
        logic               actual_taken;
        logic               predicted_taken;
        logic [ADDR_W-1:0]  resolved_target;
    } item_t;

    typedef struct packed
    {
        logic               stall_res;
        logic               redirect_valid;
        logic [ADDR_W-1:0]  redirect_addr;
        logic [ADDR_W-1:0]  miss_tag;
    } result_t;

endpackage

// ----- sv/bt2_table.sv -----
module bt2_table #(
    parameter int ENTRIES = 8,
    parameter int PC_STEP = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  bt2_pkg::item_t   item,
    output bt2_pkg::result_t result
);
    import bt2_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [ADDR_W-1:0] branch_reg  [ENTRIES];
    logic [ADDR_W-1:0] branch_next [ENTRIES];
    logic [ADDR_W-1:0] target_reg  [ENTRIES];
    logic [ADDR_W-1:0] target_next [ENTRIES];
    logic [CNT_W-1:0]  cnt_reg     [ENTRIES];
    logic [CNT_W-1:0]  cnt_next    [ENTRIES];
    logic [IW-1:0]     victim_reg;
    logic [IW-1:0]     victim_next;

    logic [ENTRIES-1:0] match;
    logic               found;
    logic [IW-1:0]      slot;
    logic [CNT_W-1:0]   init_cnt;
    logic               is_alloc;

    assign is_alloc = (item.kind == KIND_ALLOC);
    assign init_cnt = item.start_taken ? CNT_STRONG_TAKEN : CNT_STRONG_NOT_TAKEN;

    // parallel compare; allocate also takes an empty entry
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (branch_reg[i] == item.branch_addr) ||
                       (is_alloc && (branch_reg[i] == '0));
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        found = |match;
        slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                slot = IW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            branch_next[i] = branch_reg[i];
            target_next[i] = target_reg[i];
            cnt_next[i]    = cnt_reg[i];
        end
        victim_next = victim_reg;
        result      = '0;

        if (is_alloc)
        begin
            if (!item.already_hit)
            begin
                if (found)
                begin
                    branch_next[slot] = item.branch_addr;
                    cnt_next[slot]    = init_cnt;
                    result.stall_res  = 1'b1;
                end
                else
                begin
                    branch_next[victim_reg] = item.branch_addr;
                    target_next[victim_reg] = '0;
                    cnt_next[victim_reg]    = init_cnt;
                    if (victim_reg == IW'(ENTRIES - 1))
                    begin
                        victim_next = '0;
                    end
                    else
                    begin
                        victim_next = victim_reg + IW'(1);
                    end
                end
            end
        end
        else if (found)
        begin
            target_next[slot] = item.resolved_target;
            if (item.actual_taken)
            begin
                if (cnt_reg[slot] != CNT_STRONG_TAKEN)
                begin
                    cnt_next[slot] = cnt_reg[slot] + CNT_W'(1);
                end
            end
            else if (cnt_reg[slot] != CNT_STRONG_NOT_TAKEN)
            begin
                cnt_next[slot] = cnt_reg[slot] - CNT_W'(1);
            end
            if (item.actual_taken != item.predicted_taken)
            begin
                result.redirect_valid = 1'b1;
                result.miss_tag       = item.branch_addr;
                result.redirect_addr  = item.actual_taken ? item.resolved_target :
                                        item.branch_addr + ADDR_W'(PC_STEP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                branch_reg[i] <= '0;
                target_reg[i] <= '0;
                cnt_reg[i]    <= CNT_STRONG_TAKEN;
            end
            victim_reg <= '0;
        end
        else if (step_en)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                branch_reg[i] <= branch_next[i];
                target_reg[i] <= target_next[i];
                cnt_reg[i]    <= cnt_next[i];
            end
            victim_reg <= victim_next;
        end
    end

endmodule

// ----- sv/branch_target_buffer_2bit.sv -----
// Path: input register, then result register; the result register loads only when the
// output register is empty or m_axis_tready is high, so a stall holds the item back.
// Throughput: one item per cycle while m_axis_tready is high; the table lookup and update
// are combinational, made of the parallel compare over all entries and the priority pick.
// Reset (rst_n low, asynchronous): all entries empty with target 0 and counter
// strong taken, victim pointer 0, both pipeline registers empty.
module branch_target_buffer_2bit #(
    parameter int ENTRIES = 8,
    parameter int PC_STEP = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] branch_addr, [32] already_hit, [33] start_taken, [34] actual_taken,
    // [35] predicted_taken, [67:36] resolved_target, [71:68] zero
    input  logic [bt2_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] stall_res, [1] redirect_valid, [33:2] redirect_addr, [65:34] miss_tag,
    // [71:66] zero
    output logic [bt2_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bt2_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    item_t   in_item;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    advance;
    logic    step_en;

    assign in_item.kind            = kind_t'(s_axis_tuser);
    assign in_item.branch_addr     = s_axis_tdata[31:0];
    assign in_item.already_hit     = s_axis_tdata[32];
    assign in_item.start_taken     = s_axis_tdata[33];
    assign in_item.actual_taken    = s_axis_tdata[34];
    assign in_item.predicted_taken = s_axis_tdata[35];
    assign in_item.resolved_target = s_axis_tdata[67:36];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item;
        end
        if (step_en)
        begin
            out_res_reg <= step_res;
        end
    end

    bt2_table #(
        .ENTRIES (ENTRIES),
        .PC_STEP (PC_STEP)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (step_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.miss_tag, out_res_reg.redirect_addr,
                            out_res_reg.redirect_valid, out_res_reg.stall_res};

endmodule

// ----- sv/bt2_checker.sv -----
module bt2_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bt2_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bt2_pkg::*;

    // an item either allocates or resolves, never both
    a_stall_xor_redirect: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("stall and redirect raised together");

    // address fields are zero without a redirect
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[65:2] == '0))
        else $error("redirect fields nonzero without redirect");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71:66] == '0))
        else $error("tdata padding nonzero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind branch_target_buffer_2bit bt2_checker u_bt2_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/branch_target_buffer_2bit_tb.sv -----
`timescale 1ns / 100ps

import bt2_pkg::*;

// Shadow copy of the branch table; predicts one outcome per accepted item
class btb_mirror;
    localparam int DEPTH = 8;
    localparam int STEP  = 4;

    logic [ADDR_W-1:0] slot_branch [DEPTH];
    logic [ADDR_W-1:0] slot_target [DEPTH];
    logic [CNT_W-1:0]  slot_count  [DEPTH];
    int                victim;
    result_t           outcomes_due [$];
    int                errors;

    function new();
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_branch[i] = '0;
            slot_target[i] = '0;
            slot_count[i]  = CNT_STRONG_TAKEN;
        end
        victim = 0;
        errors = 0;
    endfunction

    function int find_slot(logic [ADDR_W-1:0] pc, bit free_ok);
        for (int i = 0; i < DEPTH; i++)
            if (slot_branch[i] == pc || (free_ok && slot_branch[i] == '0))
                return i;
        return -1;
    endfunction

    function void apply_item(item_t it);
        result_t         r;
        int              slot;
        logic [CNT_W-1:0] init;
        r = '0;
        init = it.start_taken ? CNT_STRONG_TAKEN : CNT_STRONG_NOT_TAKEN;
        if (it.kind == KIND_ALLOC)
        begin
            slot = find_slot(it.branch_addr, 1'b1);
            if (!it.already_hit)
            begin
                if (slot >= 0)
                begin
                    // free or matching entry: target kept
                    slot_branch[slot] = it.branch_addr;
                    slot_count[slot]  = init;
                    r.stall_res = 1'b1;
                end
                else
                begin
                    slot_branch[victim] = it.branch_addr;
                    slot_target[victim] = '0;
                    slot_count[victim]  = init;
                    victim = (victim == DEPTH - 1) ? 0 : victim + 1;
                end
            end
        end
        else
        begin
            slot = find_slot(it.branch_addr, 1'b0);
            if (slot >= 0)
            begin
                slot_target[slot] = it.resolved_target;
                if (it.actual_taken)
                begin
                    if (!it.predicted_taken)
                    begin
                        r.redirect_valid = 1'b1;
                        r.redirect_addr  = it.resolved_target;
                        r.miss_tag       = it.branch_addr;
                    end
                    if (slot_count[slot] != CNT_STRONG_TAKEN)
                        slot_count[slot] = slot_count[slot] + CNT_W'(1);
                end
                else
                begin
                    if (it.predicted_taken)
                    begin
                        r.redirect_valid = 1'b1;
                        r.redirect_addr  = it.branch_addr + ADDR_W'(STEP);
                        r.miss_tag       = it.branch_addr;
                    end
                    if (slot_count[slot] != CNT_STRONG_NOT_TAKEN)
                        slot_count[slot] = slot_count[slot] - CNT_W'(1);
                end
            end
        end
        outcomes_due.push_back(r);
    endfunction

    task report(string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    task check_outcome(result_t got);
        result_t want;
        if (outcomes_due.size() == 0)
        begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = outcomes_due.pop_front();
        if (got.stall_res !== want.stall_res)
            report($sformatf("stall_res %b, want %b", got.stall_res, want.stall_res));
        if (got.redirect_valid !== want.redirect_valid)
            report($sformatf("redirect_valid %b, want %b",
                             got.redirect_valid, want.redirect_valid));
        if (got.redirect_addr !== want.redirect_addr)
            report($sformatf("redirect_addr %h, want %h",
                             got.redirect_addr, want.redirect_addr));
        if (got.miss_tag !== want.miss_tag)
            report($sformatf("miss_tag %h, want %h", got.miss_tag, want.miss_tag));
    endtask
endclass

module branch_target_buffer_2bit_tb;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int QUIET_TAIL     = 300;
    localparam int POOL_SIZE      = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    btb_mirror         table_mirror;
    bit                quiet = 1'b0;
    bit                calm = 1'b0;
    int                hold_left = 0;
    int                idle_cycles = 0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    branch_target_buffer_2bit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[31:0]  = it.branch_addr;
        d[32]    = it.already_hit;
        d[33]    = it.start_taken;
        d[34]    = it.actual_taken;
        d[35]    = it.predicted_taken;
        d[67:36] = it.resolved_target;
        return d;
    endfunction

    function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
        result_t r;
        r.stall_res      = d[0];
        r.redirect_valid = d[1];
        r.redirect_addr  = d[33:2];
        r.miss_tag       = d[65:34];
        return r;
    endfunction

    function automatic item_t make_item(kind_t k, logic [ADDR_W-1:0] pc, logic hit,
                                        logic st, logic act, logic pred,
                                        logic [ADDR_W-1:0] tgt);
        item_t it;
        it.kind            = k;
        it.branch_addr     = pc;
        it.already_hit     = hit;
        it.start_taken     = st;
        it.actual_taken    = act;
        it.predicted_taken = pred;
        it.resolved_target = tgt;
        return it;
    endfunction

    task automatic refill_pool();
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            a = $urandom;
            if ($urandom_range(0, 1) == 0)
                a[1:0] = 2'b00;
            if ($urandom_range(0, 19) == 0)
                a = 32'hFFFF_FFFC;
            addr_pool[i] = a;
        end
    endtask

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it.kind            = kind_t'(1'($urandom_range(0, 1)));
        it.start_taken     = 1'($urandom_range(0, 1));
        it.actual_taken    = 1'($urandom_range(0, 1));
        it.predicted_taken = 1'($urandom_range(0, 1));
        it.already_hit     = ($urandom_range(0, 4) == 0);
        it.resolved_target = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            it.branch_addr = '0;
        else if (pick < 14)
            it.branch_addr = $urandom;
        else
            it.branch_addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        table_mirror.apply_item(it);
    endtask

    // result side: check each transfer, then pick tready for the next cycle
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            table_mirror.check_outcome(unpack_result(m_axis_tdata));
        if (hold_left == 0 && !quiet && !calm && $urandom_range(0, 4) == 0)
            hold_left = $urandom_range(1, 8);
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        table_mirror = new();
        refill_pool();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(KIND_ALLOC, 32'h0000_1000, 0, 1, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h0000_1000, 1, 0, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h0000_1000, 0, 0, 1, 1, 32'hFFFF_FFFF));
        // zero address claims an empty slot that stays empty
        send_item(make_item(KIND_ALLOC, 32'h0, 0, 1, 0, 0, 32'h0));
        send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 1, 0, 32'hFFFF_FFFF));
        send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 0, 1, 32'h0000_2000));
        send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 1, 1, 32'h0000_2000));
        send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 1, 1, 32'h0000_2000));
        repeat (3)
            send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 0, 0, 32'h0000_3000));
        send_item(make_item(KIND_RESOLVE, 32'hDEAD_0000, 1, 1, 1, 0, 32'h0000_4000));
        send_item(make_item(KIND_RESOLVE, 32'h0, 0, 0, 0, 1, 32'h1234_5678));
        // step past the top of the address space wraps to zero
        send_item(make_item(KIND_ALLOC, 32'hFFFF_FFFC, 0, 0, 0, 0, 32'h0));
        send_item(make_item(KIND_RESOLVE, 32'hFFFF_FFFC, 0, 0, 0, 1, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'hFFFF_FFFF, 0, 1, 1, 1, 32'hFFFF_FFFF));
        send_item(make_item(KIND_ALLOC, 32'h8000_0000, 0, 0, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h7FFF_FFFF, 0, 1, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h0000_2000, 0, 0, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h0000_2004, 0, 1, 0, 0, 32'h0));
        send_item(make_item(KIND_ALLOC, 32'h0000_2008, 0, 0, 0, 0, 32'h0));
        // table full: victim replacement, then the evicted branch misses
        send_item(make_item(KIND_ALLOC, 32'h0000_3000, 0, 1, 0, 0, 32'h0));
        send_item(make_item(KIND_RESOLVE, 32'h0000_1000, 0, 0, 1, 0, 32'h0000_5000));
        send_item(make_item(KIND_ALLOC, 32'h0, 0, 0, 0, 0, 32'h0));
        send_item(make_item(KIND_RESOLVE, 32'h0000_3000, 0, 0, 1, 0, 32'h0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                refill_pool();
            if (n % 100 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_item(random_item());
        end
        s_axis_tvalid <= 1'b0;

        while (table_mirror.outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
